FILE: src/cpmt_pkg.sv
`default_nettype none

package cpmt_pkg;

  localparam int ENTRIES = 32;
  localparam int ADDR_W  = 24;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 5;

  localparam logic [ADDR_W-1:0] FOLD_TEST = 24'h40e000;
  localparam logic [ADDR_W-1:0] FOLD_BASE = 24'h7e0000;
  localparam logic [ADDR_W-1:0] FOLD_OFFS = 24'h001fff;
  localparam logic [BYTE_W-1:0] NO_DATA   = 8'h00;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_SELECT = 3'b100
  } state_e;

  typedef struct packed {
    logic capture;
    logic match;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // low-ram mirror: banks 00-3f/80-bf, offsets 0000-1fff go to 7e
  function automatic logic [ADDR_W-1:0] fold_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if ((a & FOLD_TEST) == '0) begin
      r = FOLD_BASE | (a & FOLD_OFFS);
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/cpmt_if.sv
`default_nettype none

interface cpmt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [cpmt_pkg::IDX_W-1:0]    entry_index;
  logic [cpmt_pkg::ADDR_W-1:0]   address;
  logic [cpmt_pkg::BYTE_W-1:0]   patch_byte;
  logic                          entry_enable;

  modport source (output valid, operation, entry_index, address, patch_byte, entry_enable,
                  input ready);
  modport sink (input valid, operation, entry_index, address, patch_byte, entry_enable,
                output ready);
endinterface

interface cpmt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [cpmt_pkg::BYTE_W-1:0]   read_data;

  modport source (output valid, hit, read_data, input ready);
  modport sink (input valid, hit, read_data, output ready);
endinterface

interface cpmt_cfg_if;
  logic valid;
  logic ready;
  logic system_enable;

  modport source (output valid, system_enable, input ready);
  modport sink (input valid, system_enable, output ready);
endinterface

`default_nettype wire

FILE: src/cpmt_ctrl.sv
`default_nettype none

module cpmt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire cpmt_pkg::sts_t sts_i,
  output cpmt_pkg::cmd_t      cmd_o
);

  cpmt_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == cpmt_pkg::ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.match   = 1'b0;
    cmd_o.load    = 1'b0;
    unique case (state_q)
      cpmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = cpmt_pkg::ST_MATCH;
        end
      end
      cpmt_pkg::ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = cpmt_pkg::ST_SELECT;
      end
      cpmt_pkg::ST_SELECT: begin
        // wait until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = cpmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cpmt_dp.sv
`default_nettype none

module cpmt_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cpmt_pkg::cmd_t              cmd_i,
  output cpmt_pkg::sts_t                   sts_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_enable_i,
  input  wire logic                        operation_i,
  input  wire logic [cpmt_pkg::IDX_W-1:0]  entry_index_i,
  input  wire logic [cpmt_pkg::ADDR_W-1:0] address_i,
  input  wire logic [cpmt_pkg::BYTE_W-1:0] patch_byte_i,
  input  wire logic                        entry_enable_i,
  output logic                             rsp_valid_o,
  input  wire logic                        rsp_ready_i,
  output logic                             hit_o,
  output logic [cpmt_pkg::BYTE_W-1:0]      read_data_o
);

  logic                        sys_en_q;
  logic                        op_q;
  logic [cpmt_pkg::IDX_W-1:0]  idx_q;
  logic [cpmt_pkg::ADDR_W-1:0] addr_q;
  logic [cpmt_pkg::BYTE_W-1:0] byte_q;
  logic                        en_q;

  logic [cpmt_pkg::ADDR_W-1:0] slot_addr_q [cpmt_pkg::ENTRIES];
  logic [cpmt_pkg::BYTE_W-1:0] slot_byte_q [cpmt_pkg::ENTRIES];
  logic [cpmt_pkg::ENTRIES-1:0] slot_valid_q;

  logic [cpmt_pkg::ENTRIES-1:0] match_q, match_d;
  logic [cpmt_pkg::ENTRIES-1:0] first;
  logic [cpmt_pkg::ENTRIES-1:0] slot_we;
  logic [cpmt_pkg::BYTE_W-1:0]  sel_data;
  logic                         is_write;

  logic                         rsp_valid_q;
  logic                         hit_q;
  logic [cpmt_pkg::BYTE_W-1:0]  data_q;

  assign is_write = cmd_i.match && (op_q == cpmt_pkg::OP_WRITE);

  always_comb begin
    for (int i = 0; i < cpmt_pkg::ENTRIES; i++) begin
      slot_we[i] = is_write && (int'(idx_q) == i);
      match_d[i] = (op_q == cpmt_pkg::OP_READ) && sys_en_q && slot_valid_q[i]
                   && (slot_addr_q[i] == addr_q);
    end
  end

  // isolate the lowest set match bit, then gather its byte
  assign first = match_q & (~match_q + 1'b1);

  always_comb begin
    sel_data = cpmt_pkg::NO_DATA;
    for (int i = 0; i < cpmt_pkg::ENTRIES; i++) begin
      sel_data = sel_data | (first[i] ? slot_byte_q[i] : cpmt_pkg::NO_DATA);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      idx_q  <= entry_index_i;
      addr_q <= cpmt_pkg::fold_addr(address_i);
      byte_q <= patch_byte_i;
      en_q   <= entry_enable_i;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
    end
    if (cmd_i.load) begin
      hit_q  <= |match_q;
      data_q <= sel_data;
    end
    for (int i = 0; i < cpmt_pkg::ENTRIES; i++) begin
      if (slot_we[i]) begin
        slot_addr_q[i] <= addr_q;
        slot_byte_q[i] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_en_q     <= 1'b1;
      slot_valid_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sys_en_q <= cfg_enable_i;
      end
      for (int i = 0; i < cpmt_pkg::ENTRIES; i++) begin
        if (slot_we[i]) begin
          slot_valid_q[i] <= en_q;
        end
      end
      if (cmd_i.load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign hit_o          = hit_q;
  assign read_data_o    = data_q;

endmodule

`default_nettype wire

FILE: src/cheat_patch_match_table.sv
// a result is registered after the capture, compare and select states; select waits while the output register is full
// one item at a time (capture, parallel compare, priority select); a new item is accepted only when idle
// the output register holds a result until taken; the next item is accepted meanwhile
// reset: asynchronous, active low; clears all slot valid flags, system enable goes to 1
// slot addresses and bytes are not cleared
`default_nettype none

module cheat_patch_match_table (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cpmt_cfg_if.sink   cfg_i,
  cpmt_req_if.sink   req_i,
  cpmt_rsp_if.source rsp_o
);

  cpmt_pkg::cmd_t cmd;
  cpmt_pkg::sts_t sts;
  logic           in_ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = in_ready;

  cpmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpmt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_i.valid),
    .cfg_enable_i   (cfg_i.system_enable),
    .operation_i    (req_i.operation),
    .entry_index_i  (req_i.entry_index),
    .address_i      (req_i.address),
    .patch_byte_i   (req_i.patch_byte),
    .entry_enable_i (req_i.entry_enable),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .hit_o          (rsp_o.hit),
    .read_data_o    (rsp_o.read_data)
  );

endmodule

`default_nettype wire

FILE: src/cpmt_checker.sv
`default_nettype none

module cpmt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        req_operation,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic                        rsp_hit,
  input wire logic [cpmt_pkg::BYTE_W-1:0] rsp_data
);

  // one item in flight: nothing taken the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted while previous item still in compare");

  // a miss always reads as zero data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_hit) |-> (rsp_data == cpmt_pkg::NO_DATA))
    else $error("miss with non-zero read data");

  // a write item never reports a hit
  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready && (req_operation == cpmt_pkg::OP_WRITE)) |=> ##2
    (rsp_valid && !rsp_hit) || !$rose(rsp_valid))
    else $error("write item produced a hit");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) && $stable(rsp_data)))
    else $error("result changed while stalled");

endmodule

bind cheat_patch_match_table cpmt_checker u_cpmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid     (req_i.valid),
  .req_ready     (req_i.ready),
  .req_operation (req_i.operation),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .rsp_hit       (rsp_o.hit),
  .rsp_data      (rsp_o.read_data)
);

`default_nettype wire
